[hdl/gkc_pkg.sv]
// ----------------------------------------------------------------------------
// gkc_pkg
// Shared types and constants of the Gaussian kernel coefficient core.
// ----------------------------------------------------------------------------
package gkc_pkg;

  localparam int unsigned GKC_FRAC_BITS  = 24;
  localparam int unsigned GKC_MAX_RADIUS = 16;

  localparam logic [1:0] CMD_2D_RAW  = 2'd0;
  localparam logic [1:0] CMD_2D_NORM = 2'd1;
  localparam logic [1:0] CMD_1D_RAW  = 2'd2;
  localparam logic [1:0] CMD_1D_NORM = 2'd3;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_SIGMA  = 1'b1;

  localparam logic [4:0]  RADIUS_RESET = 5'd5;
  localparam logic [15:0] SIGMA_RESET  = 16'd448;

  localparam logic [63:0] Q62_ONE             = 64'h4000_0000_0000_0000;
  localparam logic [63:0] INV_TWO_PI_Q64      = 64'h28BE_60DB_9391_054A;
  localparam logic [63:0] INV_SQRT_TWO_PI_Q56 = 64'h0066_2114_CF50_D942;

  localparam logic [4:0] HORNER_TERMS = 5'd22;
  localparam logic [2:0] SQUARINGS    = 3'd5;
  localparam logic [6:0] T_DIV_STEPS  = 7'd62;
  localparam logic [6:0] DIV_STEPS    = 7'd64;

  // Reciprocals for the series steps: floor(t / n) = (t * m) >> sh for t < 2^62,
  // with m = ceil(2^sh / n) and sh = 62 + ceil(log2 n).
  typedef logic [31:0][63:0] recip_tab_t;
  typedef logic [31:0][6:0]  rsh_tab_t;

  function automatic int unsigned recip_lg(int unsigned n);
    int unsigned lg;
    lg = 0;
    for (int j = 0; j < 5; j++) begin
      if ((32'd1 << lg) < n) begin
        lg = lg + 1;
      end
    end
    return lg;
  endfunction

  function automatic recip_tab_t recip_table();
    recip_tab_t   tab;
    logic [127:0] num;
    int unsigned  d;
    for (int i = 0; i < 32; i++) begin
      d      = (i == 0) ? 1 : i;
      num    = 128'd1 << (62 + recip_lg(d));
      tab[i] = 64'((num + 128'(d) - 128'd1) / 128'(d));
    end
    return tab;
  endfunction

  function automatic rsh_tab_t rsh_table();
    rsh_tab_t    tab;
    int unsigned d;
    for (int i = 0; i < 32; i++) begin
      d      = (i == 0) ? 1 : i;
      tab[i] = 7'(62 + recip_lg(d));
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = recip_table();
  localparam rsh_tab_t   RECIP_SH  = rsh_table();

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD_IN,
    OP_K2_MAIN,
    OP_K2_K,
    OP_EXP_ZERO,
    OP_TDIV_GO,
    OP_TDIV_GET,
    OP_HDIV_GO,
    OP_HDIV_GET,
    OP_HMUL_GO,
    OP_HMUL_GET,
    OP_SQ_GO,
    OP_SQ_GET,
    OP_SAVE_E,
    OP_SUM_FIRST,
    OP_SUM_ADD,
    OP_FMUL_GO,
    OP_FMUL_GET,
    OP_FDIV1_GO,
    OP_FDIV1_GET,
    OP_FDIV2_GO,
    OP_FDIV2_GET,
    OP_RESULT
  } gkc_op_t;

  typedef struct packed {
    gkc_op_t    op;
    logic       req_ready;
    logic [4:0] n;
    logic [4:0] k;
  } gkc_cmd_t;

  typedef struct packed {
    logic       req_valid;
    logic       oor;
    logic       exp_zero;
    logic       norm;
    logic       two_stage;
    logic [4:0] lim;
    logic       div_done;
    logic       mul_done;
    logic       out_blocked;
  } gkc_sts_t;

endpackage

[hdl/gkc_req_if.sv]
// ----------------------------------------------------------------------------
// gkc_req_if
// Request channel: kernel kind and tap offsets.
// ----------------------------------------------------------------------------
interface gkc_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [4:0] x_offset;
  logic signed [4:0] y_offset;

  modport source (output valid, output command, output x_offset, output y_offset,
                  input ready);
  modport sink (input valid, input command, input x_offset, input y_offset,
                output ready);
endinterface

[hdl/gkc_rsp_if.sv]
// ----------------------------------------------------------------------------
// gkc_rsp_if
// Response channel: coefficient and flags.
// ----------------------------------------------------------------------------
interface gkc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] coefficient;
  logic        saturated;
  logic        out_of_range;

  modport source (output valid, output coefficient, output saturated,
                  output out_of_range, input ready);
  modport sink (input valid, input coefficient, input saturated,
                input out_of_range, output ready);
endinterface

[hdl/gaussian_kernel_coefficient_core.sv]
// ----------------------------------------------------------------------------
// gaussian_kernel_coefficient_core
// Gaussian blur kernel coefficient, unsigned Q8.24, for one tap per item.
//
//   channel | dir | handshake        | payload
//   req     | in  | valid/ready      | command, x_offset, y_offset
//   rsp     | out | valid/ready      | coefficient, saturated, out_of_range
//   cfg     | in  | cfg_we           | cfg_index, cfg_data
//
// One item at a time. Each exp term is a 62-bit serial division, 22 series
// steps of two multiplications each and five squarings. Normalised kinds add
// radius sum terms to the main term. A term whose exponent underflows is set
// to zero without the series. Out-of-range items skip the exp terms.
// Synchronous reset; no clearing pass. A waiting result does not block the
// next item, which is accepted once the previous one is in the output register.
// ----------------------------------------------------------------------------
module gaussian_kernel_coefficient_core #(
  parameter int unsigned FRAC_BITS  = gkc_pkg::GKC_FRAC_BITS,
  parameter int unsigned MAX_RADIUS = gkc_pkg::GKC_MAX_RADIUS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  gkc_req_if.sink     req,
  gkc_rsp_if.source   rsp
);
  import gkc_pkg::*;

  gkc_cmd_t cmd;
  gkc_sts_t sts;

  gkc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  gkc_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[hdl/gkc_div.sv]
// ----------------------------------------------------------------------------
// gkc_div
// Restoring divider, one quotient bit per cycle, 64-bit operands.
// ----------------------------------------------------------------------------
module gkc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rem_init,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  input  logic [6:0]  steps,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem, quo[63]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[63:0] : trial[63:0];
      quo <= {quo[62:0], ge};
    end
  end

  assign quotient = quo;

endmodule

[hdl/gkc_mul.sv]
// ----------------------------------------------------------------------------
// gkc_mul
// 64x64 multiplier built from one 32x32 multiplier over four partial products.
// ----------------------------------------------------------------------------
module gkc_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] product
);

  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [31:0]  ma;
  logic [31:0]  mb;
  logic [63:0]  pp;
  logic [127:0] acc;
  logic [127:0] ppx;

  always_comb begin
    unique case (cnt)
      3'd1: begin
        ma = a_r[63:32];
        mb = b_r[31:0];
      end
      3'd2: begin
        ma = a_r[31:0];
        mb = b_r[63:32];
      end
      3'd3: begin
        ma = a_r[63:32];
        mb = b_r[63:32];
      end
      default: begin
        ma = a_r[31:0];
        mb = b_r[31:0];
      end
    endcase
    // pp holds the partial product of the previous step
    unique case (cnt)
      3'd1:      ppx = {64'b0, pp};
      3'd2:      ppx = {32'b0, pp, 32'b0};
      3'd3:      ppx = {32'b0, pp, 32'b0};
      3'd4:      ppx = {pp, 64'b0};
      default:   ppx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
    end else if (busy) begin
      pp  <= 64'(ma) * 64'(mb);
      acc <= acc + ppx;
    end
  end

  assign product = acc;

endmodule

[hdl/gkc_dp.sv]
// ----------------------------------------------------------------------------
// gkc_dp
// Datapath: configuration, operand registers, exp series, final divisions.
// ----------------------------------------------------------------------------
module gkc_dp #(
  parameter int unsigned FRAC_BITS  = gkc_pkg::GKC_FRAC_BITS,
  parameter int unsigned MAX_RADIUS = gkc_pkg::GKC_MAX_RADIUS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  gkc_req_if.sink           req,
  gkc_rsp_if.source         rsp,
  input  gkc_pkg::gkc_cmd_t cmd,
  output gkc_pkg::gkc_sts_t sts
);
  import gkc_pkg::*;

  localparam int unsigned SH_2D  = 38 - FRAC_BITS;
  localparam int unsigned SH_1D  = 46 - FRAC_BITS;
  localparam int unsigned SH_1N  = FRAC_BITS - 6;
  localparam int unsigned R_CAP  = (MAX_RADIUS > 31) ? 31 : MAX_RADIUS;
  localparam logic [4:0]  R_CAPV = 5'(R_CAP);

  logic [4:0]   radius;
  logic [15:0]  sigma;
  logic [1:0]   cmd_r;
  logic [4:0]   ax;
  logic [4:0]   ay;
  logic [9:0]   k2;
  logic [63:0]  tq;
  logic [63:0]  qn;
  logic [63:0]  p;
  logic [63:0]  e_main;
  logic [63:0]  tsum;
  logic [63:0]  fnum;
  logic [63:0]  v;
  logic         out_valid;
  logic [31:0]  coef_o;
  logic         sat_o;
  logic         oor_o;

  logic [4:0]   r_eff;
  logic [4:0]   lim;
  logic [15:0]  s;
  logic [31:0]  s2;
  logic [19:0]  num;
  logic         twod;
  logic         oor;
  logic [4:0]   x_abs;
  logic [4:0]   y_abs;

  logic         div_start;
  logic [63:0]  div_rem;
  logic [63:0]  div_dvd;
  logic [63:0]  div_dvs;
  logic [6:0]   div_steps;
  logic         div_done;
  logic [63:0]  div_q;
  logic         mul_start;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic         mul_done;
  logic [127:0] mul_p;
  logic [63:0]  fd1_dvs;
  logic [63:0]  fd1_num;
  logic [63:0]  fd2_dvs;
  logic [63:0]  fd2_num;

  always_comb begin
    x_abs = req.x_offset[4] ? 5'(-req.x_offset) : req.x_offset;
    y_abs = req.y_offset[4] ? 5'(-req.y_offset) : req.y_offset;
    r_eff = (radius == 5'd0) ? 5'd1 : radius;
    if (r_eff > R_CAPV) begin
      r_eff = R_CAPV;
    end
    lim  = r_eff - 5'd1;
    twod = ~cmd_r[1];
    oor  = (ax > lim) || (twod && (ay > lim));
    s    = (sigma == 16'd0) ? 16'd1 : sigma;
    s2   = 32'(s) * 32'(s);
    num  = {k2, 10'b0};
  end

  always_comb begin
    unique case (cmd_r)
      CMD_2D_RAW: begin
        fd1_dvs = 64'(s2) << SH_2D;
        fd1_num = fnum + (fd1_dvs >> 1);
      end
      CMD_1D_RAW: begin
        fd1_dvs = 64'(s) << SH_1D;
        fd1_num = fnum + (fd1_dvs >> 1);
      end
      CMD_1D_NORM: begin
        fd1_dvs = tsum >> SH_1N;
        fd1_num = e_main + (fd1_dvs >> 1);
      end
      default: begin
        fd1_dvs = tsum >> 24;
        fd1_num = {e_main[62:0], 1'b0} + (fd1_dvs >> 1);
      end
    endcase
    fd2_dvs = tsum >> 25;
    fd2_num = (v << FRAC_BITS) + (fd2_dvs >> 1);
  end

  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_dvd   = '0;
    div_dvs   = 64'd1;
    div_steps = DIV_STEPS;
    mul_start = 1'b0;
    mul_a     = p;
    mul_b     = p;
    unique case (cmd.op)
      OP_TDIV_GO: begin
        div_start = 1'b1;
        div_rem   = 64'(num);
        div_dvs   = 64'(s2);
        div_steps = T_DIV_STEPS;
      end
      OP_HDIV_GO: begin
        mul_start = 1'b1;
        mul_a     = tq;
        mul_b     = RECIP_TAB[cmd.n];
      end
      OP_FDIV1_GO: begin
        div_start = 1'b1;
        div_dvd   = fd1_num;
        div_dvs   = fd1_dvs;
      end
      OP_FDIV2_GO: begin
        div_start = 1'b1;
        div_dvd   = fd2_num;
        div_dvs   = fd2_dvs;
      end
      OP_HMUL_GO: begin
        mul_start = 1'b1;
        mul_a     = qn;
      end
      OP_SQ_GO: begin
        mul_start = 1'b1;
      end
      OP_FMUL_GO: begin
        mul_start = 1'b1;
        mul_a     = e_main;
        mul_b     = (cmd_r == CMD_2D_RAW) ? INV_TWO_PI_Q64 : INV_SQRT_TWO_PI_Q56;
      end
      default: begin
      end
    endcase
  end

  gkc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  gkc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= RADIUS_RESET;
      sigma     <= SIGMA_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RADIUS: radius <= cfg_data[4:0];
          CFG_SIGMA:  sigma  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.op == OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD_IN: begin
        cmd_r <= req.command;
        ax    <= x_abs;
        ay    <= y_abs;
      end
      OP_K2_MAIN:   k2 <= 10'(ax) * 10'(ax) + (twod ? 10'(ay) * 10'(ay) : 10'd0);
      OP_K2_K:      k2 <= 10'(cmd.k) * 10'(cmd.k);
      OP_EXP_ZERO:  p <= '0;
      OP_TDIV_GET: begin
        tq <= div_q;
        p  <= Q62_ONE;
      end
      OP_HDIV_GET:  qn <= 64'(mul_p >> RECIP_SH[cmd.n]);
      OP_HMUL_GET:  p <= Q62_ONE - mul_p[125:62];
      OP_SQ_GET:    p <= mul_p[125:62];
      OP_SAVE_E:    e_main <= p;
      OP_SUM_FIRST: tsum <= p >> 6;
      OP_SUM_ADD:   tsum <= tsum + {p[63:6], 1'b0};
      OP_FMUL_GET:  fnum <= (cmd_r == CMD_2D_RAW) ? (mul_p[127:64] >> 8) : mul_p[127:64];
      OP_FDIV1_GET: v <= div_q;
      OP_FDIV2_GET: v <= div_q;
      OP_RESULT: begin
        oor_o  <= oor;
        sat_o  <= ~oor && (v[63:32] != 32'd0);
        if (oor) begin
          coef_o <= '0;
        end else if (v[63:32] != 32'd0) begin
          coef_o <= '1;
        end else begin
          coef_o <= v[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready        = cmd.req_ready;
  assign rsp.valid        = out_valid;
  assign rsp.coefficient  = coef_o;
  assign rsp.saturated    = sat_o;
  assign rsp.out_of_range = oor_o;

  always_comb begin
    sts.req_valid   = req.valid;
    sts.oor         = oor;
    sts.exp_zero    = ({12'b0, num} >= s2);
    sts.norm        = cmd_r[0];
    sts.two_stage   = (cmd_r == CMD_2D_NORM);
    sts.lim         = lim;
    sts.div_done    = div_done;
    sts.mul_done    = mul_done;
    sts.out_blocked = out_valid && ~rsp.ready;
  end

endmodule

[hdl/gkc_ctrl.sv]
// ----------------------------------------------------------------------------
// gkc_ctrl
// Sequencer: exp series per term, normalisation sum, final divisions.
// ----------------------------------------------------------------------------
module gkc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  gkc_pkg::gkc_sts_t sts,
  output gkc_pkg::gkc_cmd_t cmd
);
  import gkc_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_CHECK    = 19'h00002,
    S_EXP_CHK  = 19'h00004,
    S_TDIV_W   = 19'h00008,
    S_HDIV_GO  = 19'h00010,
    S_HDIV_W   = 19'h00020,
    S_HMUL_GO  = 19'h00040,
    S_HMUL_W   = 19'h00080,
    S_SQ_GO    = 19'h00100,
    S_SQ_W     = 19'h00200,
    S_EXP_END  = 19'h00400,
    S_K2_LOAD  = 19'h00800,
    S_FMUL_GO  = 19'h01000,
    S_FMUL_W   = 19'h02000,
    S_FDIV1_GO = 19'h04000,
    S_FDIV1_W  = 19'h08000,
    S_FDIV2_GO = 19'h10000,
    S_FDIV2_W  = 19'h20000,
    S_DONE     = 19'h40000
  } state_t;

  state_t     state, state_next;
  logic [4:0] n, n_next;
  logic [2:0] sq, sq_next;
  logic [4:0] k, k_next;
  logic       in_sum, in_sum_next;

  always_comb begin
    state_next    = state;
    n_next        = n;
    sq_next       = sq;
    k_next        = k;
    in_sum_next   = in_sum;
    cmd.op        = OP_NONE;
    cmd.req_ready = 1'b0;
    cmd.n         = n;
    cmd.k         = k;
    unique case (state)
      S_IDLE: begin
        cmd.req_ready = 1'b1;
        if (sts.req_valid) begin
          cmd.op     = OP_LOAD_IN;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.oor) begin
          state_next = S_DONE;
        end else begin
          cmd.op      = OP_K2_MAIN;
          in_sum_next = 1'b0;
          state_next  = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (sts.exp_zero) begin
          cmd.op     = OP_EXP_ZERO;
          state_next = S_EXP_END;
        end else begin
          cmd.op     = OP_TDIV_GO;
          state_next = S_TDIV_W;
        end
      end
      S_TDIV_W: begin
        if (sts.div_done) begin
          cmd.op     = OP_TDIV_GET;
          n_next     = HORNER_TERMS;
          state_next = S_HDIV_GO;
        end
      end
      S_HDIV_GO: begin
        cmd.op     = OP_HDIV_GO;
        state_next = S_HDIV_W;
      end
      S_HDIV_W: begin
        if (sts.mul_done) begin
          cmd.op     = OP_HDIV_GET;
          state_next = S_HMUL_GO;
        end
      end
      S_HMUL_GO: begin
        cmd.op     = OP_HMUL_GO;
        state_next = S_HMUL_W;
      end
      S_HMUL_W: begin
        if (sts.mul_done) begin
          cmd.op = OP_HMUL_GET;
          if (n == 5'd1) begin
            sq_next    = '0;
            state_next = S_SQ_GO;
          end else begin
            n_next     = n - 5'd1;
            state_next = S_HDIV_GO;
          end
        end
      end
      S_SQ_GO: begin
        cmd.op     = OP_SQ_GO;
        state_next = S_SQ_W;
      end
      S_SQ_W: begin
        if (sts.mul_done) begin
          cmd.op = OP_SQ_GET;
          if (sq == SQUARINGS - 3'd1) begin
            state_next = S_EXP_END;
          end else begin
            sq_next    = sq + 3'd1;
            state_next = S_SQ_GO;
          end
        end
      end
      S_EXP_END: begin
        if (!in_sum) begin
          cmd.op = OP_SAVE_E;
          if (sts.norm) begin
            in_sum_next = 1'b1;
            k_next      = '0;
            state_next  = S_K2_LOAD;
          end else begin
            state_next = S_FMUL_GO;
          end
        end else begin
          cmd.op = (k == 5'd0) ? OP_SUM_FIRST : OP_SUM_ADD;
          if (k == sts.lim) begin
            state_next = S_FDIV1_GO;
          end else begin
            k_next     = k + 5'd1;
            state_next = S_K2_LOAD;
          end
        end
      end
      S_K2_LOAD: begin
        cmd.op     = OP_K2_K;
        state_next = S_EXP_CHK;
      end
      S_FMUL_GO: begin
        cmd.op     = OP_FMUL_GO;
        state_next = S_FMUL_W;
      end
      S_FMUL_W: begin
        if (sts.mul_done) begin
          cmd.op     = OP_FMUL_GET;
          state_next = S_FDIV1_GO;
        end
      end
      S_FDIV1_GO: begin
        cmd.op     = OP_FDIV1_GO;
        state_next = S_FDIV1_W;
      end
      S_FDIV1_W: begin
        if (sts.div_done) begin
          cmd.op     = OP_FDIV1_GET;
          state_next = sts.two_stage ? S_FDIV2_GO : S_DONE;
        end
      end
      S_FDIV2_GO: begin
        cmd.op     = OP_FDIV2_GO;
        state_next = S_FDIV2_W;
      end
      S_FDIV2_W: begin
        if (sts.div_done) begin
          cmd.op     = OP_FDIV2_GET;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_blocked) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      n      <= '0;
      sq     <= '0;
      k      <= '0;
      in_sum <= 1'b0;
    end else begin
      state  <= state_next;
      n      <= n_next;
      sq     <= sq_next;
      k      <= k_next;
      in_sum <= in_sum_next;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the Gaussian kernel coefficient core. Requests go in through
// the request channel with random idling. Each accepted item is scored
// against a bit-accurate model of the fixed point exponential series, the
// normalisation sum and the rounding divisions. Covered: kernel and sigma
// corners, out-of-range offsets, output back-pressure and random runs.
// ----------------------------------------------------------------------------
module tb_top;
  import gkc_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 40_000_000;

  typedef struct packed {
    logic [31:0] coefficient;
    logic        saturated;
    logic        out_of_range;
  } coef_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  gkc_req_if req ();
  gkc_rsp_if rsp ();

  gaussian_kernel_coefficient_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  coef_t           coef_q[$];
  int unsigned     fails;
  longint unsigned cycles;
  logic [4:0]      radius_reg;
  logic [15:0]     sigma_reg;
  bit              quiet;
  bit              hold_go;
  int unsigned     hold_left;
  int unsigned     rsp_stall;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] mul_top(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[127:64];
  endfunction

  function automatic logic [63:0] div_near(logic [63:0] n, logic [63:0] d);
    return (n + (d >> 1)) / d;
  endfunction

  // exp(-k2 / (2 s^2)) in Q62, s2 = S^2 with S in Q8.8
  function automatic logic [63:0] exp_term(logic [63:0] k2, logic [63:0] s2);
    logic [63:0] num, w, f1, r1, f2, t, p;
    num = k2 << 10;
    if (num >= s2) return 64'd0;
    w  = num << 31;
    f1 = w / s2;
    r1 = w % s2;
    f2 = (r1 << 31) / s2;
    t  = (f1 << 31) | f2;
    p  = Q62_ONE;
    for (int n = 22; n >= 1; n--) p = Q62_ONE - mul_q62(t / n, p);
    for (int i = 0; i < 5; i++) p = mul_q62(p, p);
    return p;
  endfunction

  function automatic int unsigned tap_limit(logic [4:0] r);
    int unsigned rc;
    rc = (r == 0) ? 1 : r;
    if (rc > GKC_MAX_RADIUS) rc = GKC_MAX_RADIUS;
    return rc - 1;
  endfunction

  function automatic coef_t kernel_coef(logic [1:0] cmd, logic signed [4:0] x,
                                        logic signed [4:0] y);
    coef_t       res;
    logic [63:0] ax, ay, lim, s, s2, k2, e, tsum, v1, val;
    bit          twod;
    twod = (cmd == CMD_2D_RAW) || (cmd == CMD_2D_NORM);
    ax   = (x < 0) ? -x : x;
    ay   = (y < 0) ? -y : y;
    lim  = tap_limit(radius_reg);
    res  = '0;
    if (ax > lim || (twod && ay > lim)) begin
      res.out_of_range = 1'b1;
      return res;
    end
    s  = (sigma_reg == 0) ? 64'd1 : {48'd0, sigma_reg};
    s2 = s * s;
    k2 = ax * ax + (twod ? ay * ay : 64'd0);
    e  = exp_term(k2, s2);
    if (cmd == CMD_2D_RAW) begin
      val = div_near(mul_top(e, INV_TWO_PI_Q64) >> 8, s2 << (38 - GKC_FRAC_BITS));
    end else if (cmd == CMD_1D_RAW) begin
      val = div_near(mul_top(e, INV_SQRT_TWO_PI_Q56), s << (46 - GKC_FRAC_BITS));
    end else begin
      tsum = exp_term(0, s2) >> 6;
      for (longint unsigned k = 1; k <= lim; k++)
        tsum += (exp_term(k * k, s2) >> 6) << 1;
      if (cmd == CMD_1D_NORM) begin
        val = div_near(e, tsum >> (GKC_FRAC_BITS - 6));
      end else begin
        v1  = div_near(e << 1, tsum >> 24);
        val = div_near(v1 << GKC_FRAC_BITS, tsum >> 25);
      end
    end
    if (val > 64'hFFFF_FFFF) begin
      res.coefficient = 32'hFFFF_FFFF;
      res.saturated   = 1'b1;
    end else begin
      res.coefficient = val[31:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(negedge clk) begin
    coef_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (coef_q.size() == 0) begin
        $display("%0t: unexpected item coef %h sat %b oor %b", $time,
                 rsp.coefficient, rsp.saturated, rsp.out_of_range);
        fails++;
      end else begin
        want = coef_q.pop_front();
        if (rsp.coefficient !== want.coefficient) begin
          $display("%0t: coefficient exp %h got %h", $time, want.coefficient,
                   rsp.coefficient);
          fails++;
        end
        if (rsp.saturated !== want.saturated) begin
          $display("%0t: saturated exp %b got %b", $time, want.saturated,
                   rsp.saturated);
          fails++;
        end
        if (rsp.out_of_range !== want.out_of_range) begin
          $display("%0t: out_of_range exp %b got %b", $time, want.out_of_range,
                   rsp.out_of_range);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      rsp_stall <= 0;
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= 6000;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_stall <= rsp_stall - 1;
      rsp.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rsp_stall <= $urandom_range(0, 15);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_tap(logic [1:0] cmd, logic signed [4:0] x, logic signed [4:0] y);
    req.valid    <= 1'b1;
    req.command  <= cmd;
    req.x_offset <= x;
    req.y_offset <= y;
    do @(negedge clk); while (!req.ready);
    @(posedge clk);
    coef_q.push_back(kernel_coef(cmd, x, y));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain;
    req.valid <= 1'b0;
    while (coef_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RADIUS) radius_reg = data[4:0];
    else sigma_reg = data;
  endtask

  task automatic set_kernel(logic [15:0] r, logic [15:0] s);
    drain();
    write_cfg(CFG_RADIUS, r);
    write_cfg(CFG_SIGMA, s);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_defaults;
    send_tap(CMD_2D_RAW, 0, 0);
    send_tap(CMD_2D_NORM, 0, 0);
    send_tap(CMD_1D_RAW, 4, 0);
    send_tap(CMD_1D_NORM, -4, 0);
    send_tap(CMD_2D_RAW, 4, -4);
    send_tap(CMD_2D_RAW, 5, 0);
    send_tap(CMD_1D_RAW, 0, 15);
    send_tap(CMD_2D_RAW, -16, 0);
    send_tap(CMD_2D_NORM, 0, -5);
  endtask

  task automatic test_config_corners;
    set_kernel(0, 448);
    send_tap(CMD_2D_NORM, 0, 0);
    send_tap(CMD_2D_RAW, 1, 0);
    set_kernel(31, 16'hFFFF);
    send_tap(CMD_1D_NORM, 15, 0);
    send_tap(CMD_2D_RAW, -15, 15);
    send_tap(CMD_2D_NORM, 15, -15);
    set_kernel(2, 0);
    send_tap(CMD_2D_RAW, 0, 0);
    send_tap(CMD_1D_RAW, 1, 0);
    send_tap(CMD_1D_NORM, 1, 0);
    set_kernel(16, 1);
    send_tap(CMD_2D_RAW, 0, 0);
    send_tap(CMD_1D_NORM, -15, 0);
  endtask

  task automatic test_backpressure;
    set_kernel(3, 300);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < 4; i++)
      send_tap(CMD_2D_RAW, 5'($urandom_range(0, 4) - 2), 5'($urandom_range(0, 4) - 2));
  endtask

  task automatic test_sender_pause;
    send_tap(CMD_1D_RAW, 1, 0);
    req.valid <= 1'b0;
    while (coef_q.size() != 0) @(posedge clk);
    send_tap(CMD_1D_NORM, -2, 0);
    send_tap(CMD_2D_RAW, 0, 2);
  endtask

  function automatic logic [15:0] pick_sigma();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 255));
      1: return 16'($urandom_range(256, 4096));
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(100, 1200));
    endcase
  endfunction

  task automatic test_random;
    int unsigned       lim, count;
    logic signed [4:0] x, y;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) begin
        set_kernel(16'($urandom_range(5, 31)), pick_sigma());
        count = 20;
      end else begin
        set_kernel(16'($urandom_range(1, 4)), pick_sigma());
        count = 85;
      end
      if (ph == 9) quiet = 1;
      lim = tap_limit(radius_reg);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          x = 5'($urandom_range(0, 2 * lim) - lim);
          y = 5'($urandom_range(0, 2 * lim) - lim);
        end else begin
          x = 5'($urandom_range(0, 31));
          y = 5'($urandom_range(0, 31));
        end
        send_tap(2'($urandom_range(0, 3)), x, y);
      end
    end
  endtask

  initial begin
    fails        = 0;
    cycles       = 0;
    quiet        = 0;
    hold_go      = 0;
    radius_reg   = RADIUS_RESET;
    sigma_reg    = SIGMA_RESET;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_RADIUS;
    cfg_data     = '0;
    req.valid    = 1'b0;
    req.command  = CMD_2D_RAW;
    req.x_offset = '0;
    req.y_offset = '0;
    rsp.ready    = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_config_corners();
    test_backpressure();
    test_sender_pause();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
